[design/sobel_pkg.sv]
`timescale 1ns / 1ps

package sobel_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 11'd150;
  localparam logic [CFG_W-1:0] WIDTH_RESET     = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET    = 11'd240;

  // Frame geometry limits
  localparam int DIM_MIN    = 3;
  localparam int HEIGHT_MAX = 1024;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic               edge_res;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } edge_out_t;

endpackage

[design/sobel_edge_threshold.sv]
`timescale 1ns / 1ps
// The result for interior pixel (c,r) follows pixel (c+1,r+1) through the stage 1,
//   stage 2 and output registers to res. Throughput: one pixel per cycle unless res
//   stalls, set by the single read-modify-write of the line store.
// Reset: restores threshold 150, width 320, height 240, clears position counters, window
//   and pipeline; the line store is not cleared and needs no clearing pass.
module sobel_edge_threshold #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  sobel_pkg::pix_in_t            pix,
  output logic                          res_valid,
  input  logic                          res_stall,
  output sobel_pkg::edge_out_t          res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sobel_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sobel_pkg::CFG_W-1:0]   cfg_data
);
  import sobel_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > CFG_W) ? WW : CFG_W;
  localparam int HW = CFG_W;
  localparam int GW = 12;

  // Configuration registers
  logic [CFG_W-1:0] edge_threshold;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THRESHOLD_RESET;
      frame_width    <= WIDTH_RESET;
      frame_height   <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: edge_threshold <= cfg_data;
        REG_WIDTH:     frame_width    <= cfg_data;
        REG_HEIGHT:    frame_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  logic [XW-1:0] fw_ext;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    fw_ext = XW'(frame_width);
    if (fw_ext < XW'(DIM_MIN)) begin
      w_eff = WW'(DIM_MIN);
    end else if (fw_ext > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    if (frame_height < HW'(DIM_MIN)) begin
      h_eff = HW'(DIM_MIN);
    end else if (frame_height > HW'(HEIGHT_MAX)) begin
      h_eff = HW'(HEIGHT_MAX);
    end else begin
      h_eff = frame_height;
    end
  end

  // Pipeline control
  logic accept;
  logic s1_valid, s1_adv, s2_valid, s2_ready, out_ready;
  logic s1_emit;

  assign out_ready = !res_valid || !res_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_adv    = s1_valid && (!s1_emit || s2_ready);
  assign pix_stall = s1_valid && !s1_adv;
  assign accept    = pix_valid && !pix_stall;

  // Position of the incoming pixel and of the one after it
  logic [CW-1:0]      col_counter;
  logic [COORD_W-1:0] row_counter;
  logic [WW-1:0]      c0, c1;
  logic [HW-1:0]      r0, r1;
  logic               emit0, last0;

  always_comb begin
    if (pix.frame_start) begin
      c0 = '0;
      r0 = '0;
    end else begin
      c0 = WW'(col_counter);
      r0 = HW'(row_counter);
    end
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + HW'(1);
    end
    if (r0 >= h_eff) begin
      r0 = '0;
    end
    c1 = c0 + WW'(1);
    r1 = r0;
    if (c1 >= w_eff) begin
      c1 = '0;
      r1 = r0 + HW'(1);
    end
    if (r1 >= h_eff) begin
      r1 = '0;
    end
    emit0 = (c0 >= WW'(2)) && (r0 >= HW'(2));
    last0 = (c0 == w_eff - WW'(1)) && (r0 == h_eff - HW'(1));
  end

  // Advance position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
    end else if (accept) begin
      col_counter <= CW'(c1);
      row_counter <= COORD_W'(r1);
    end
  end

  // Line store: upper row in the high byte, middle row in the low byte
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata;
  logic [2*PIX_W-1:0] fwd_data;
  logic               fwd;

  logic [PIX_W-1:0]   s1_px;
  logic [CW-1:0]      s1_col;
  logic [COORD_W-1:0] s1_row;
  logic               s1_last;
  logic [PIX_W-1:0]   up_eff, mid_eff;

  // Bypass the store when the previous transaction wrote the same column
  assign up_eff  = fwd ? fwd_data[2*PIX_W-1:PIX_W] : rdata[2*PIX_W-1:PIX_W];
  assign mid_eff = fwd ? fwd_data[PIX_W-1:0]       : rdata[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= line_mem[CW'(c0)];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= {mid_eff, s1_px};
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd      <= s1_valid && (CW'(c0) == s1_col);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= pix.pixel;
      s1_col   <= CW'(c0);
      s1_row   <= COORD_W'(r0);
      s1_emit  <= emit0;
      s1_last  <= last0;
      fwd_data <= {mid_eff, s1_px};
    end
  end

  // Window and gradients of the shifted window
  logic [PIX_W-1:0] win [9];
  logic signed [GW-1:0] p00, p01, p02, p10, p12, p20, p21, p22;
  logic signed [GW-1:0] gx, gy;

  always_comb begin
    p00 = $signed(GW'(win[1]));
    p01 = $signed(GW'(win[2]));
    p02 = $signed(GW'(up_eff));
    p10 = $signed(GW'(win[4]));
    p12 = $signed(GW'(mid_eff));
    p20 = $signed(GW'(win[7]));
    p21 = $signed(GW'(win[8]));
    p22 = $signed(GW'(s1_px));
    gx  = (p02 - p00) + ((p12 - p10) <<< 1) + (p22 - p20);
    gy  = (p20 - p00) + ((p21 - p01) <<< 1) + (p22 - p02);
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= up_eff;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= mid_eff;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= s1_px;
    end
  end

  // Stage 2: hold gradients of interior pixels
  logic signed [GW-1:0] s2_gx, s2_gy;
  logic [COORD_W-1:0]   s2_col, s2_row;
  logic                 s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_adv && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_adv && s1_emit) begin
      s2_gx   <= gx;
      s2_gy   <= gy;
      s2_col  <= COORD_W'(s1_col - CW'(1));
      s2_row  <= s1_row - COORD_W'(1);
      s2_last <= s1_last;
    end
  end

  // Manhattan magnitude and threshold
  logic [GW-1:0] abs_gx, abs_gy, mag;

  always_comb begin
    abs_gx = s2_gx[GW-1] ? GW'(-s2_gx) : GW'(s2_gx);
    abs_gy = s2_gy[GW-1] ? GW'(-s2_gy) : GW'(s2_gy);
    mag    = abs_gx + abs_gy;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      res.edge_res <= mag > GW'(edge_threshold);
      res.col      <= s2_col;
      res.row      <= s2_row;
      res.last     <= s2_last;
    end
  end

  // Bypass only follows a transaction that wrote the store in the cycle before
  assert property (@(posedge clk) disable iff (rst)
    $rose(fwd) |-> $past(s1_valid && s1_adv))
    else $error("line store bypass without a preceding write");

  // A held stage 2 result moves into a freed output register
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && out_ready |=> res_valid)
    else $error("stage 2 result lost on its way to the output");

  // The input is held only while stage 1 is occupied
  assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> s1_valid && s1_emit && s2_valid && res_valid && res_stall)
    else $error("input stalled with room in the pipeline");

endmodule
